// ===== sv/pfcb_pkg.sv =====
// Types and constants shared by the pixel fill/copy/blend datapath.
`timescale 1ns / 1ps

package pfcb_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int PIX_W    = CHAN_W * NUM_CHAN;
    localparam int ALPHA_CH = 3;
    localparam int PROD_W   = 2 * CHAN_W;

    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CHAN_W-1:0] ROUND_BIAS   = 8'd127;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OP_MODE    = 1'b0,
        REG_FILL_COLOR = 1'b1
    } cfg_reg_t;

    localparam int MODE_W = 2;
    typedef enum logic [MODE_W-1:0] {
        MODE_FILL  = 2'd0,
        MODE_COPY  = 2'd1,
        MODE_BLEND = 2'd2
    } op_mode_t;

    typedef struct packed {
        op_mode_t          op_mode;
        logic [PIX_W-1:0]  fill_color;
    } cfg_t;

endpackage

// ===== sv/pfcb_if.sv =====
// Valid/ready channel interfaces for pixel pairs and result pixels.
`timescale 1ns / 1ps

interface pfcb_in_if;
    logic                       valid;
    logic                       ready;
    logic [pfcb_pkg::PIX_W-1:0] src_pixel;
    logic [pfcb_pkg::PIX_W-1:0] dst_pixel;

    modport source (output valid, output src_pixel, output dst_pixel, input ready);
    modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface pfcb_out_if;
    logic                       valid;
    logic                       ready;
    logic [pfcb_pkg::PIX_W-1:0] out_pixel;
    logic                       write_enable;

    modport source (output valid, output out_pixel, output write_enable, input ready);
    modport sink   (input valid, input out_pixel, input write_enable, output ready);
endinterface

// ===== sv/pfcb_cfg.sv =====
// Configuration registers: operation mode and fill color.
`timescale 1ns / 1ps

module pfcb_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [pfcb_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [pfcb_pkg::PIX_W-1:0]     wr_data,
    output pfcb_pkg::cfg_t                 cfg
);

    pfcb_pkg::op_mode_t          op_mode_reg;
    logic [pfcb_pkg::PIX_W-1:0]  fill_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg    <= pfcb_pkg::MODE_BLEND;
            fill_color_reg <= '0;
        end
        else if (wr_en)
        begin
            case (pfcb_pkg::cfg_reg_t'(wr_index))
                pfcb_pkg::REG_OP_MODE:
                    op_mode_reg <= pfcb_pkg::op_mode_t'(wr_data[pfcb_pkg::MODE_W-1:0]);
                pfcb_pkg::REG_FILL_COLOR:
                    fill_color_reg <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.op_mode    = op_mode_reg;
    assign cfg.fill_color = fill_color_reg;

endmodule

// ===== sv/pfcb_mix.sv =====
// One channel of source-over mixing: (s*a + d*(255-a) + 127) / 255.
`timescale 1ns / 1ps

module pfcb_mix (
    input  logic [pfcb_pkg::CHAN_W-1:0] s,
    input  logic [pfcb_pkg::CHAN_W-1:0] d,
    input  logic [pfcb_pkg::CHAN_W-1:0] a,
    output logic [pfcb_pkg::CHAN_W-1:0] q
);

    localparam int PROD_W = pfcb_pkg::PROD_W;

    logic [pfcb_pkg::CHAN_W-1:0] ia;
    logic [pfcb_pkg::PROD_W-1:0] sum;
    logic [pfcb_pkg::PROD_W:0]   adj;

    assign ia  = pfcb_pkg::ALPHA_OPAQUE - a;
    // max sum is 255*255 + 127, fits in 16 bits
    assign sum = PROD_W'(s) * PROD_W'(a) + PROD_W'(d) * PROD_W'(ia)
               + PROD_W'(pfcb_pkg::ROUND_BIAS);
    // x/255 == (x + 1 + (x >> 8)) >> 8 for x < 65535
    assign adj = {1'b0, sum} + 17'd1 + 17'(sum >> pfcb_pkg::CHAN_W);
    assign q   = adj[pfcb_pkg::PROD_W-1:pfcb_pkg::CHAN_W];

endmodule

// ===== sv/pixel_fill_copy_blend.sv =====
// Pixel fill/copy/source-over blend datapath, BGRA8888.
// Pipeline: two register stages (input reg, result reg); a word moves from the
// input reg into the result reg once the result reg is empty or being drained.
// Throughput: one word per cycle; both stages advance when the downstream
// result register is empty or being drained.
// Reset: clears both stage valid flags, op_mode to blend, fill color to zero.
`timescale 1ns / 1ps

module pixel_fill_copy_blend (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [pfcb_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [pfcb_pkg::PIX_W-1:0]     wr_data,
    pfcb_in_if.sink                        item,
    pfcb_out_if.source                     result
);

    localparam int CW = pfcb_pkg::CHAN_W;

    pfcb_pkg::cfg_t cfg;

    logic                       in_valid_reg;
    logic [pfcb_pkg::PIX_W-1:0] src_reg;
    logic [pfcb_pkg::PIX_W-1:0] dst_reg;

    logic                       out_valid_reg;
    logic [pfcb_pkg::PIX_W-1:0] out_pixel_reg;
    logic                       we_reg;

    logic [pfcb_pkg::PIX_W-1:0] out_pixel_next;
    logic                       we_next;
    logic [pfcb_pkg::PIX_W-1:0] mixed;
    logic [CW-1:0]              src_alpha;
    logic                       out_open;

    pfcb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    assign out_open   = !out_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || out_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            src_reg <= item.src_pixel;
            dst_reg <= item.dst_pixel;
        end
    end

    assign src_alpha = src_reg[pfcb_pkg::ALPHA_CH*CW +: CW];

    // alpha lane uses s = 255: (255a + d*ia + 127)/255 == a + (d*ia + 127)/255
    for (genvar ch = 0; ch < pfcb_pkg::NUM_CHAN; ch++)
    begin : g_lane
        logic [CW-1:0] s_chan;
        assign s_chan = (ch == pfcb_pkg::ALPHA_CH) ? pfcb_pkg::ALPHA_OPAQUE
                                                   : src_reg[ch*CW +: CW];
        pfcb_mix u_mix (
            .s (s_chan),
            .d (dst_reg[ch*CW +: CW]),
            .a (src_alpha),
            .q (mixed[ch*CW +: CW])
        );
    end

    always_comb
    begin
        out_pixel_next = dst_reg;
        we_next        = 1'b0;
        case (cfg.op_mode)
            pfcb_pkg::MODE_FILL:
            begin
                out_pixel_next = cfg.fill_color;
                we_next        = 1'b1;
            end
            pfcb_pkg::MODE_COPY:
            begin
                out_pixel_next = src_reg;
                we_next        = 1'b1;
            end
            pfcb_pkg::MODE_BLEND:
            begin
                if (src_alpha == pfcb_pkg::ALPHA_CLEAR)
                begin
                    out_pixel_next = dst_reg;
                    we_next        = 1'b0;
                end
                else if (src_alpha == pfcb_pkg::ALPHA_OPAQUE)
                begin
                    out_pixel_next = {pfcb_pkg::ALPHA_OPAQUE,
                                      src_reg[pfcb_pkg::ALPHA_CH*CW-1:0]};
                    we_next        = 1'b1;
                end
                else
                begin
                    out_pixel_next = mixed;
                    we_next        = 1'b1;
                end
            end
            default:
            begin
                out_pixel_next = dst_reg;
                we_next        = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_open && in_valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
            we_reg        <= we_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_pixel    = out_pixel_reg;
    assign result.write_enable = we_reg;

endmodule

// ===== tb/sv/tb_pixel_fill_copy_blend.sv =====
// Self-checking testbench for the pixel fill/copy/blend datapath.
`timescale 1ns / 1ps

module tb_pixel_fill_copy_blend;

    // mode 3 is not decoded by the block: no write, destination passed through
    localparam logic [pfcb_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 800;

    typedef struct packed {
        logic [pfcb_pkg::PIX_W-1:0] pixel;
        logic                       write_enable;
    } pixel_write_t;

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    logic [pfcb_pkg::CFG_IDX_W-1:0] wr_index;
    logic [pfcb_pkg::PIX_W-1:0] wr_data;

    pfcb_in_if  item_ch ();
    pfcb_out_if result_ch ();

    pixel_fill_copy_blend DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    // predictor copy of the configuration
    logic [pfcb_pkg::MODE_W-1:0] mode_q;
    logic [pfcb_pkg::PIX_W-1:0]  fill_q;

    pixel_write_t expected_writes[$];
    int mismatch_count;
    int words_by_mode[4];
    int results_written;
    int results_skipped;
    bit steady_flow;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pixel_write_t composite_pixel(
        input logic [pfcb_pkg::MODE_W-1:0] mode,
        input logic [pfcb_pkg::PIX_W-1:0]  fill,
        input logic [pfcb_pkg::PIX_W-1:0]  src,
        input logic [pfcb_pkg::PIX_W-1:0]  dst
    );
        localparam int CW = pfcb_pkg::CHAN_W;
        localparam int AC = pfcb_pkg::ALPHA_CH;
        pixel_write_t w;
        int a;
        int ia;
        int mixed;
        w.pixel = dst;
        w.write_enable = 1'b0;
        case (mode)
            pfcb_pkg::MODE_FILL:
            begin
                w.pixel = fill;
                w.write_enable = 1'b1;
            end
            pfcb_pkg::MODE_COPY:
            begin
                w.pixel = src;
                w.write_enable = 1'b1;
            end
            pfcb_pkg::MODE_BLEND:
            begin
                a = int'(src[AC*CW +: CW]);
                ia = int'(pfcb_pkg::ALPHA_OPAQUE) - a;
                if (a == int'(pfcb_pkg::ALPHA_OPAQUE))
                begin
                    w.pixel = src;
                    w.pixel[AC*CW +: CW] = pfcb_pkg::ALPHA_OPAQUE;
                    w.write_enable = 1'b1;
                end
                else if (a != int'(pfcb_pkg::ALPHA_CLEAR))
                begin
                    for (int c = 0; c < AC; c++)
                    begin
                        mixed = (int'(src[c*CW +: CW]) * a
                                 + int'(dst[c*CW +: CW]) * ia
                                 + int'(pfcb_pkg::ROUND_BIAS))
                                / int'(pfcb_pkg::ALPHA_OPAQUE);
                        w.pixel[c*CW +: CW] = mixed[CW-1:0];
                    end
                    mixed = a + (int'(dst[AC*CW +: CW]) * ia
                                 + int'(pfcb_pkg::ROUND_BIAS))
                                / int'(pfcb_pkg::ALPHA_OPAQUE);
                    w.pixel[AC*CW +: CW] = mixed[CW-1:0];
                    w.write_enable = 1'b1;
                end
            end
            default:
            begin
                w.pixel = dst;
                w.write_enable = 1'b0;
            end
        endcase
        return w;
    endfunction

    // downstream stall: about a quarter of cycles, none during steady flow
    always @(posedge clk)
    begin
        result_ch.ready <= steady_flow || ($urandom_range(99) >= 25);
    end

    always @(posedge clk)
    begin
        pixel_write_t exp_w;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_writes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result word out_pixel=%h write_enable=%b",
                         $time, result_ch.out_pixel, result_ch.write_enable);
            end
            else
            begin
                exp_w = expected_writes.pop_front();
                if (result_ch.out_pixel !== exp_w.pixel)
                begin
                    mismatch_count++;
                    $display("%0t: out_pixel expected %h actual %h",
                             $time, exp_w.pixel, result_ch.out_pixel);
                end
                if (result_ch.write_enable !== exp_w.write_enable)
                begin
                    mismatch_count++;
                    $display("%0t: write_enable expected %b actual %b",
                             $time, exp_w.write_enable, result_ch.write_enable);
                end
                if (result_ch.write_enable)
                    results_written++;
                else
                    results_skipped++;
            end
        end
    end

    // Leaves valid high on return so back-to-back words need no extra edge.
    task automatic send_pixel_pair(input logic [pfcb_pkg::PIX_W-1:0] src,
                                   input logic [pfcb_pkg::PIX_W-1:0] dst);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 25)
            gap = $urandom_range(1, 2);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.src_pixel <= src;
        item_ch.dst_pixel <= dst;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        expected_writes.push_back(composite_pixel(mode_q, fill_q, src, dst));
        words_by_mode[mode_q]++;
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mode_word may carry junk above the mode field; the register keeps the low bits
    task automatic set_config(input logic [pfcb_pkg::PIX_W-1:0] mode_word,
                              input logic [pfcb_pkg::PIX_W-1:0] fill);
        drain_results();
        wr_en    <= 1'b1;
        wr_index <= pfcb_pkg::REG_OP_MODE;
        wr_data  <= mode_word;
        @(posedge clk);
        mode_q = mode_word[pfcb_pkg::MODE_W-1:0];
        wr_index <= pfcb_pkg::REG_FILL_COLOR;
        wr_data  <= fill;
        @(posedge clk);
        fill_q = fill;
        wr_en <= 1'b0;
    endtask

    function automatic logic [pfcb_pkg::PIX_W-1:0] random_blend_src();
        localparam int CW = pfcb_pkg::CHAN_W;
        localparam int AC = pfcb_pkg::ALPHA_CH;
        logic [pfcb_pkg::PIX_W-1:0] px;
        int pick;
        px = $urandom;
        pick = $urandom_range(99);
        if (pick < 20)
            px[AC*CW +: CW] = pfcb_pkg::ALPHA_CLEAR;
        else if (pick < 40)
            px[AC*CW +: CW] = pfcb_pkg::ALPHA_OPAQUE;
        return px;
    endfunction

    // blend straight out of reset, no register writes yet
    task automatic test_reset_blend();
        send_pixel_pair(32'h00FF_FFFF, 32'hFFFF_FFFF);
        send_pixel_pair(32'h0012_3456, 32'h89AB_CDEF);
        send_pixel_pair(32'hFF00_0000, 32'hFFFF_FFFF);
        send_pixel_pair(32'hFF12_3456, 32'h0000_0000);
        send_pixel_pair(32'h80FF_FFFF, 32'h0000_0000);
        send_pixel_pair(32'h8000_0000, 32'hFFFF_FFFF);
        send_pixel_pair(32'h01FF_FFFF, 32'hFFFF_FFFF);
        send_pixel_pair(32'hFEFF_FFFF, 32'h0000_0000);
        send_pixel_pair(32'h7F80_40C0, 32'hC040_8033);
        send_pixel_pair(32'h0100_0000, 32'h0000_0000);
        drain_results();
    endtask

    task automatic test_fill();
        set_config(32'(pfcb_pkg::MODE_FILL), 32'hFFFF_FFFF);
        send_pixel_pair(32'h0000_0000, 32'h0000_0000);
        send_pixel_pair(32'hFFFF_FFFF, 32'h1234_5678);
        set_config(32'(pfcb_pkg::MODE_FILL), 32'h0000_0000);
        send_pixel_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_config(32'(pfcb_pkg::MODE_FILL), 32'hA5C3_5A3C);
        send_pixel_pair(32'h5555_AAAA, 32'hAAAA_5555);
    endtask

    task automatic test_copy();
        set_config(32'(pfcb_pkg::MODE_COPY), 32'h0F0F_F0F0);
        send_pixel_pair(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel_pair(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel_pair(32'h00AB_CDEF, 32'h1234_5678);
    endtask

    task automatic test_unused_mode();
        // junk in the upper bits of the mode write must be masked off
        set_config({30'h3FFF_FFFF, MODE_UNUSED}, 32'hDEAD_BEEF);
        send_pixel_pair(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel_pair(32'h0000_0000, 32'hFFFF_FFFF);
        set_config({30'h2AAA_AAAA, pfcb_pkg::MODE_BLEND}, 32'h0000_0000);
        send_pixel_pair(32'h4000_00FF, 32'hFF00_FF00);
    endtask

    task automatic test_random_phases();
        int sent;
        int phase_len;
        int pick;
        logic [pfcb_pkg::MODE_W-1:0] mode;
        logic [pfcb_pkg::PIX_W-1:0] fill;
        logic [pfcb_pkg::PIX_W-1:0] src;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                mode = pfcb_pkg::MODE_FILL;
            else if (pick < 30)
                mode = pfcb_pkg::MODE_COPY;
            else if (pick < 90)
                mode = pfcb_pkg::MODE_BLEND;
            else
                mode = MODE_UNUSED;
            pick = $urandom_range(9);
            fill = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
            set_config({$urandom} & 32'hFFFF_FFFC | 32'(mode), fill);
            phase_len = $urandom_range(20, 120);
            repeat (phase_len)
            begin
                src = (mode == pfcb_pkg::MODE_BLEND) ? random_blend_src() : $urandom;
                send_pixel_pair(src, $urandom);
                sent++;
            end
        end
        drain_results();
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        set_config(32'(pfcb_pkg::MODE_BLEND), 32'h0000_0000);
        repeat (150)
            send_pixel_pair(random_blend_src(), $urandom);
        drain_results();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        mismatch_count  = 0;
        results_written = 0;
        results_skipped = 0;
        steady_flow     = 1'b0;
        mode_q          = pfcb_pkg::MODE_BLEND;
        fill_q          = '0;
        foreach (words_by_mode[m])
            words_by_mode[m] = 0;
        rst_n               <= 1'b0;
        wr_en               <= 1'b0;
        wr_index            <= pfcb_pkg::REG_OP_MODE;
        wr_data             <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.src_pixel   <= '0;
        item_ch.dst_pixel   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_blend();
        test_fill();
        test_copy();
        test_unused_mode();
        test_random_phases();
        test_back_to_back();
        drain_results();

        $display("Words sent: fill %0d, copy %0d, blend %0d, unused mode %0d",
                 words_by_mode[pfcb_pkg::MODE_FILL], words_by_mode[pfcb_pkg::MODE_COPY],
                 words_by_mode[pfcb_pkg::MODE_BLEND], words_by_mode[MODE_UNUSED]);
        $display("Results checked: %0d written, %0d left unwritten, %0d mismatches",
                 results_written, results_skipped, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout at %0t with %0d results outstanding", $time, expected_writes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
